### rtl/tge_pkg.sv
// shared types and constants for the text encoding guesser
`timescale 1ns / 1ps
`default_nettype none

package tge_pkg;

	localparam int unsigned MAX_BYTES_DEF = 65536;

	typedef enum logic [1:0] {
		ENC_UTF8    = 2'd0,
		ENC_SJIS    = 2'd1,
		ENC_LATIN1  = 2'd2,
		ENC_DEFAULT = 2'd3
	} enc_t;

	// utf-8 byte-order mark
	localparam logic [7:0] BOM_0 = 8'hEF;
	localparam logic [7:0] BOM_1 = 8'hBB;
	localparam logic [7:0] BOM_2 = 8'hBF;

	// saturating increment for run and total counters
	function automatic logic [1:0] inc3(input logic [1:0] v);
		return (v == 2'd3) ? 2'd3 : v + 2'd1;
	endfunction

endpackage

`default_nettype wire

### rtl/text_encoding_guesser.sv
// top level of the text encoding guesser
`timescale 1ns / 1ps
`default_nettype none

// Guesses the encoding of a message streamed one byte per beat, with tlast
// on its final byte. One byte is taken every clock cycle, with no gaps between
// messages, unless a stalled guess holds off the input; the per-byte update of
// the candidate flags and counters is combinational after the input register.
// A guess passes through the final-state snapshot and then the output
// register. A stalled guess holds off the input only when a final byte meets
// two guesses still waiting. Byte and upper-symbol counters saturate at
// MAX_BYTES. The sjis bias bit is written on the cfg port and survives message
// ends; write it only while no message is in flight.
module text_encoding_guesser #(
	parameter int unsigned MAX_BYTES = tge_pkg::MAX_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// config write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,     // sjis bias
	// byte stream
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata, // [7:0] data_byte
	input  wire logic       s_axis_tlast, // last_byte
	// guess
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata  // [1:0] encoding, [7:2] zero
);

	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

	typedef struct packed {
		logic             u8_ok;
		logic             sj_ok;
		logic             l1_ok;
		logic             bom_ok;
		logic             multibyte;
		logic [1:0]       kana_total;
		logic [1:0]       kana_run_max;
		logic [1:0]       dbl_run_max;
		logic [CNT_W-1:0] high_other;
		logic [CNT_W-1:0] count;
	} snap_t;

	logic assume_sjis_q;

	// message state
	logic             may_u8_q, may_l1_q, may_sj_q;
	logic [1:0]       u8_pend_q;
	logic             u8_multi_q;
	logic             sj_pend_q;
	logic [1:0]       kana_total_q, kana_run_q, kana_max_q;
	logic [1:0]       dbl_run_q, dbl_max_q;
	logic [CNT_W-1:0] high_other_q, count_q;
	logic             bom_q;

	// next state
	logic             may_u8_n, may_l1_n, may_sj_n;
	logic [1:0]       u8_pend_n;
	logic             u8_multi_n;
	logic             sj_pend_n;
	logic [1:0]       kana_total_n, kana_run_n, kana_max_n;
	logic [1:0]       dbl_run_n, dbl_max_n;
	logic [CNT_W-1:0] high_other_n, count_n;
	logic             bom_n;

	logic       valid_s1, last_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	snap_t      snap_s2, snap_n;
	logic       out_valid_q;
	tge_pkg::enc_t enc_q, enc_n;

	logic out_free, s2_free, s1_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assume_sjis_q <= 1'b0;
		end else if (cfg_valid) begin
			assume_sjis_q <= cfg_data;
		end
	end

	// handshake chain
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s2_free       = !valid_s2 || out_free;
	assign s1_fire       = valid_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// per-byte update
	always_comb begin
		logic [7:0] v;
		v = byte_s1;

		may_u8_n     = may_u8_q;
		may_l1_n     = may_l1_q;
		may_sj_n     = may_sj_q;
		u8_pend_n    = u8_pend_q;
		u8_multi_n   = u8_multi_q;
		sj_pend_n    = sj_pend_q;
		kana_total_n = kana_total_q;
		kana_run_n   = kana_run_q;
		kana_max_n   = kana_max_q;
		dbl_run_n    = dbl_run_q;
		dbl_max_n    = dbl_max_q;
		high_other_n = high_other_q;
		bom_n        = bom_q;

		case (count_q)
			CNT_W'(0): if (v != tge_pkg::BOM_0) bom_n = 1'b0;
			CNT_W'(1): if (v != tge_pkg::BOM_1) bom_n = 1'b0;
			CNT_W'(2): if (v != tge_pkg::BOM_2) bom_n = 1'b0;
			default: ;
		endcase
		count_n = (count_q < MAX_CNT) ? count_q + CNT_W'(1) : MAX_CNT;

		if (may_u8_q || may_l1_q || may_sj_q) begin
			if (may_u8_q) begin
				if (u8_pend_q != 2'd0) begin
					if (!v[7]) may_u8_n = 1'b0;
					else u8_pend_n = u8_pend_q - 2'd1;
				end else if (v[7]) begin
					if (!v[6]) begin
						may_u8_n = 1'b0;
					end else if (!v[5]) begin
						u8_pend_n  = 2'd1;
						u8_multi_n = 1'b1;
					end else if (!v[4]) begin
						u8_pend_n  = 2'd2;
						u8_multi_n = 1'b1;
					end else if (!v[3]) begin
						u8_pend_n  = 2'd3;
						u8_multi_n = 1'b1;
					end else begin
						u8_pend_n = 2'd3;
						may_u8_n  = 1'b0;
					end
				end
			end

			if (may_l1_q) begin
				if (v > 8'h7F && v < 8'hA0) begin
					may_l1_n = 1'b0;
				end else if (v > 8'h9F && (v < 8'hC0 || v == 8'hD7 || v == 8'hF7)) begin
					high_other_n = (high_other_q < MAX_CNT) ?
						high_other_q + CNT_W'(1) : MAX_CNT;
				end
			end

			if (may_sj_q) begin
				if (sj_pend_q) begin
					if (v < 8'h40 || v == 8'h7F || v > 8'hFC) may_sj_n = 1'b0;
					else sj_pend_n = 1'b0;
				end else if (v == 8'h80 || v == 8'hA0 || v > 8'hEF) begin
					may_sj_n = 1'b0;
				end else if (v > 8'hA0 && v < 8'hE0) begin
					// half-width katakana
					kana_total_n = tge_pkg::inc3(kana_total_q);
					dbl_run_n    = 2'd0;
					kana_run_n   = tge_pkg::inc3(kana_run_q);
					if (kana_run_n > kana_max_q) kana_max_n = kana_run_n;
				end else if (v > 8'h7F) begin
					// double-byte lead
					sj_pend_n  = 1'b1;
					kana_run_n = 2'd0;
					dbl_run_n  = tge_pkg::inc3(dbl_run_q);
					if (dbl_run_n > dbl_max_q) dbl_max_n = dbl_run_n;
				end else begin
					kana_run_n = 2'd0;
					dbl_run_n  = 2'd0;
				end
			end
		end

		snap_n.u8_ok        = may_u8_n && (u8_pend_n == 2'd0);
		snap_n.sj_ok        = may_sj_n && !sj_pend_n;
		snap_n.l1_ok        = may_l1_n;
		snap_n.bom_ok       = bom_n && (count_n > CNT_W'(3));
		snap_n.multibyte    = u8_multi_n;
		snap_n.kana_total   = kana_total_n;
		snap_n.kana_run_max = kana_max_n;
		snap_n.dbl_run_max  = dbl_max_n;
		snap_n.high_other   = high_other_n;
		snap_n.count        = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			may_u8_q     <= 1'b1;
			may_l1_q     <= 1'b1;
			may_sj_q     <= 1'b1;
			u8_pend_q    <= 2'd0;
			u8_multi_q   <= 1'b0;
			sj_pend_q    <= 1'b0;
			kana_total_q <= 2'd0;
			kana_run_q   <= 2'd0;
			kana_max_q   <= 2'd0;
			dbl_run_q    <= 2'd0;
			dbl_max_q    <= 2'd0;
			high_other_q <= '0;
			count_q      <= '0;
			bom_q        <= 1'b1;
		end else if (s1_fire) begin
			if (last_s1) begin
				// message done, start fresh
				may_u8_q     <= 1'b1;
				may_l1_q     <= 1'b1;
				may_sj_q     <= 1'b1;
				u8_pend_q    <= 2'd0;
				u8_multi_q   <= 1'b0;
				sj_pend_q    <= 1'b0;
				kana_total_q <= 2'd0;
				kana_run_q   <= 2'd0;
				kana_max_q   <= 2'd0;
				dbl_run_q    <= 2'd0;
				dbl_max_q    <= 2'd0;
				high_other_q <= '0;
				count_q      <= '0;
				bom_q        <= 1'b1;
			end else begin
				may_u8_q     <= may_u8_n;
				may_l1_q     <= may_l1_n;
				may_sj_q     <= may_sj_n;
				u8_pend_q    <= u8_pend_n;
				u8_multi_q   <= u8_multi_n;
				sj_pend_q    <= sj_pend_n;
				kana_total_q <= kana_total_n;
				kana_run_q   <= kana_run_n;
				kana_max_q   <= kana_max_n;
				dbl_run_q    <= dbl_run_n;
				dbl_max_q    <= dbl_max_n;
				high_other_q <= high_other_n;
				count_q      <= count_n;
				bom_q        <= bom_n;
			end
		end
	end

	// final-state snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_fire && last_s1) begin
			snap_s2 <= snap_n;
		end
	end

	// decision
	always_comb begin
		logic [CNT_W+3:0] high_x10;
		logic             two_kana;
		logic             many_high;
		high_x10  = ({4'd0, snap_s2.high_other} << 3) + ({4'd0, snap_s2.high_other} << 1);
		two_kana  = (snap_s2.kana_run_max == 2'd2) && (snap_s2.kana_total == 2'd2);
		many_high = high_x10 >= {4'd0, snap_s2.count};

		if (snap_s2.u8_ok && (snap_s2.bom_ok || snap_s2.multibyte)) begin
			enc_n = tge_pkg::ENC_UTF8;
		end else if (snap_s2.sj_ok && (assume_sjis_q || snap_s2.kana_run_max == 2'd3 ||
				snap_s2.dbl_run_max == 2'd3)) begin
			enc_n = tge_pkg::ENC_SJIS;
		end else if (snap_s2.l1_ok && snap_s2.sj_ok) begin
			enc_n = (two_kana || many_high) ? tge_pkg::ENC_SJIS : tge_pkg::ENC_LATIN1;
		end else if (snap_s2.l1_ok) begin
			enc_n = tge_pkg::ENC_LATIN1;
		end else if (snap_s2.sj_ok) begin
			enc_n = tge_pkg::ENC_SJIS;
		end else if (snap_s2.u8_ok) begin
			enc_n = tge_pkg::ENC_UTF8;
		end else begin
			enc_n = tge_pkg::ENC_DEFAULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			enc_q <= enc_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, enc_q};

endmodule

`default_nettype wire
